// ----- rtl/core/mbc_pkg.sv -----
// Package for the Mahalanobis background classifier.
// Holds the widths, model size, opcode type and reset values used by the top level.
// Depends on nothing.
package mbc_pkg;

   localparam int PIXEL_COUNT  = 65536;
   localparam int PIX_ADDR_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   localparam int INDEX_W      = 16;
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 20;
   localparam int MEAN_W       = 16;
   localparam int DIFF_W       = MEAN_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int TERM_W       = PROD_W + WORD_W;
   localparam int SUM_W        = TERM_W + 3;
   localparam int QUAD_W       = SUM_W + 1;
   localparam int THRESH_W     = 32;
   localparam int THRESH_SHIFT = 24;
   localparam int CHANNELS     = 3;
   localparam int TERMS        = 2 * CHANNELS;
   localparam int PIPE_DEPTH   = 5;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd2304;

   typedef enum logic [1:0] {
      OP_LOAD_MEAN    = 2'd0,
      OP_LOAD_DIAG    = 2'd1,
      OP_LOAD_OFFDIAG = 2'd2,
      OP_CLASSIFY     = 2'd3
   } opcode_type;

endpackage

// ----- rtl/core/mahalanobis_background_classifier_top.sv -----
// Top level of the Mahalanobis background classifier.
// Holds the per-pixel model memories and the distance pipeline; uses mbc_pkg.
//
// Usage: items arrive on the req_ channel (valid/ready). Opcodes 0..2 store the
// three means (saturated to 0..65535), the diagonal or the off-diagonal inverse
// covariance terms of one pixel; they are written at the transfer and give no
// result. Opcode 3 classifies a pixel and gives one rsp_ transfer carrying the
// pixel index and the foreground flag, in the order the items were accepted.
// One item is accepted per cycle while req_ready is high: the model memories
// have one write and one read port, both used at the transfer, and the distance
// math runs in a 5-stage pipeline ahead of the output register, so a load
// followed by a classify of the same pixel in the next cycle already sees the
// new values. When the receiver stalls, results stay in the output register and
// the pipeline compresses its bubbles; req_ready falls only when every stage
// holds a classify. Reset clears the pipeline and sets threshold_sq to 9.0; the
// model memories are not cleared and must be loaded before a pixel is
// classified. csr_wr_en writes threshold_sq at once; write it only while the
// block is idle.
module mahalanobis_background_classifier_top
   import mbc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic [INDEX_W-1:0]         req_pixel_index,
   input  logic [BYTE_W-1:0]          req_blue,
   input  logic [BYTE_W-1:0]          req_green,
   input  logic [BYTE_W-1:0]          req_red,
   input  logic signed [WORD_W-1:0]   req_word_first,
   input  logic signed [WORD_W-1:0]   req_word_second,
   input  logic signed [WORD_W-1:0]   req_word_third,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_out_index,
   output logic                       rsp_foreground,
   input  logic                       csr_wr_en,
   input  logic [THRESH_W-1:0]        csr_wr_data
);

   logic [CHANNELS*MEAN_W-1:0] mean_mem [PIXEL_COUNT];
   logic [CHANNELS*WORD_W-1:0] diag_mem [PIXEL_COUNT];
   logic [CHANNELS*WORD_W-1:0] off_mem  [PIXEL_COUNT];

   logic [THRESH_W-1:0]        threshold_ff, threshold_in;
   logic [PIPE_DEPTH-1:0]      valid_ff, valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PIPE_DEPTH:0]        advance;
   logic                       accept;
   opcode_type                 opcode;
   logic [PIX_ADDR_W-1:0]      addr;
   logic [CHANNELS*MEAN_W-1:0] mean_wr;

   logic [INDEX_W-1:0]         idx_ff [PIPE_DEPTH];
   logic [CHANNELS*BYTE_W-1:0] pix0_ff;
   logic [CHANNELS*MEAN_W-1:0] mean0_ff;
   logic [CHANNELS*WORD_W-1:0] diag0_ff, diag1_ff, diag2_ff;
   logic [CHANNELS*WORD_W-1:0] off0_ff, off1_ff, off2_ff;

   logic signed [DIFF_W-1:0]   diff_ff [CHANNELS];
   logic signed [DIFF_W-1:0]   diff_in [CHANNELS];
   logic signed [PROD_W-1:0]   prod_ff [TERMS];
   logic signed [PROD_W-1:0]   prod_in [TERMS];
   logic signed [TERM_W-1:0]   term_ff [TERMS];
   logic signed [TERM_W-1:0]   term_in [TERMS];
   logic signed [SUM_W-1:0]    sum_diag_ff, sum_diag_in;
   logic signed [SUM_W-1:0]    sum_off_ff, sum_off_in;
   logic signed [QUAD_W-1:0]   quad;
   logic                       fg_in;
   logic [INDEX_W-1:0]         rsp_index_ff;
   logic                       rsp_fg_ff;

   function automatic logic [MEAN_W-1:0] sat_mean(input logic signed [WORD_W-1:0] w);
      if (w[WORD_W-1]) begin
         return '0;
      end else if (|w[WORD_W-2:MEAN_W]) begin
         return '1;
      end else begin
         return w[MEAN_W-1:0];
      end
   endfunction

   // Handshake and stage advance. A stage loads when it is empty or drains.
   always_comb begin
      advance[PIPE_DEPTH] = !rsp_valid_ff || rsp_ready;
      for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_ready = advance[0];
   assign accept    = req_valid && req_ready;
   assign opcode    = opcode_type'(req_opcode);
   assign addr      = req_pixel_index[PIX_ADDR_W-1:0];
   assign mean_wr   = {sat_mean(req_word_third), sat_mean(req_word_second),
                       sat_mean(req_word_first)};

   always_comb begin
      valid_in[0] = advance[0] ? (accept && opcode == OP_CLASSIFY) : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
      rsp_valid_in = advance[PIPE_DEPTH] ? valid_ff[PIPE_DEPTH-1] : rsp_valid_ff;
      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // Model memories: loads write at the transfer, every transfer reads.
   always_ff @(posedge clock) begin
      if (accept) begin
         case (opcode)
            OP_LOAD_MEAN: begin
               mean_mem[addr] <= mean_wr;
            end
            OP_LOAD_DIAG: begin
               diag_mem[addr] <= {req_word_third, req_word_second, req_word_first};
            end
            OP_LOAD_OFFDIAG: begin
               off_mem[addr] <= {req_word_third, req_word_second, req_word_first};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mean0_ff  <= mean_mem[addr];
         diag0_ff  <= diag_mem[addr];
         off0_ff   <= off_mem[addr];
         idx_ff[0] <= req_pixel_index;
         pix0_ff   <= {req_red, req_green, req_blue};
      end
   end

   // Distance datapath.
   always_comb begin
      for (int j = 0; j < CHANNELS; j++) begin
         diff_in[j] = $signed({1'b0, pix0_ff[j*BYTE_W +: BYTE_W], {BYTE_W{1'b0}}})
                    - $signed({1'b0, mean0_ff[j*MEAN_W +: MEAN_W]});
      end
      for (int j = 0; j < CHANNELS; j++) begin
         prod_in[j] = PROD_W'(diff_ff[j] * diff_ff[j]);
      end
      prod_in[3] = PROD_W'(diff_ff[0] * diff_ff[1]);
      prod_in[4] = PROD_W'(diff_ff[0] * diff_ff[2]);
      prod_in[5] = PROD_W'(diff_ff[1] * diff_ff[2]);
      for (int j = 0; j < CHANNELS; j++) begin
         term_in[j] = TERM_W'($signed(diag2_ff[j*WORD_W +: WORD_W]) * prod_ff[j]);
         term_in[j+CHANNELS] =
            TERM_W'($signed(off2_ff[j*WORD_W +: WORD_W]) * prod_ff[j+CHANNELS]);
      end
      sum_diag_in = SUM_W'(term_ff[0]) + SUM_W'(term_ff[1]) + SUM_W'(term_ff[2]);
      sum_off_in  = SUM_W'(term_ff[3]) + SUM_W'(term_ff[4]) + SUM_W'(term_ff[5]);
      quad        = QUAD_W'(sum_diag_ff) + (QUAD_W'(sum_off_ff) <<< 1);
      fg_in       = quad[QUAD_W-1] ||
                    (quad[QUAD_W-2:0] >=
                     (QUAD_W-1)'({threshold_ff, {THRESH_SHIFT{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         idx_ff[1] <= idx_ff[0];
         diff_ff   <= diff_in;
         diag1_ff  <= diag0_ff;
         off1_ff   <= off0_ff;
      end
      if (advance[2]) begin
         idx_ff[2] <= idx_ff[1];
         prod_ff   <= prod_in;
         diag2_ff  <= diag1_ff;
         off2_ff   <= off1_ff;
      end
      if (advance[3]) begin
         idx_ff[3] <= idx_ff[2];
         term_ff   <= term_in;
      end
      if (advance[4]) begin
         idx_ff[4]   <= idx_ff[3];
         sum_diag_ff <= sum_diag_in;
         sum_off_ff  <= sum_off_in;
      end
      if (advance[PIPE_DEPTH]) begin
         rsp_index_ff <= idx_ff[PIPE_DEPTH-1];
         rsp_fg_ff    <= fg_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_foreground = rsp_fg_ff;

`ifndef SYNTHESIS
   a_load_gives_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode != OP_CLASSIFY) |=> !valid_ff[0])
      else $error("load transfer entered the distance pipeline");

   a_classify_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_CLASSIFY) |=>
         (valid_ff[0] && idx_ff[0] == $past(req_pixel_index)))
      else $error("classify transfer did not enter the first stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline had room");
`endif

endmodule

// ----- tb/sv/mbc_foreground_checker.sv -----
// Checker for the Mahalanobis background classifier: watches the request, result
// and threshold ports, keeps its own copy of the per-pixel model and predicts each
// foreground flag in order. Uses mbc_pkg; no other dependencies.
module mbc_foreground_checker
   import mbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic [INDEX_W-1:0]       req_pixel_index,
   input  logic [BYTE_W-1:0]        req_blue,
   input  logic [BYTE_W-1:0]        req_green,
   input  logic [BYTE_W-1:0]        req_red,
   input  logic signed [WORD_W-1:0] req_word_first,
   input  logic signed [WORD_W-1:0] req_word_second,
   input  logic signed [WORD_W-1:0] req_word_third,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [INDEX_W-1:0]       rsp_out_index,
   input  logic                     rsp_foreground,
   input  logic                     csr_wr_en,
   input  logic [THRESH_W-1:0]      csr_wr_data,
   output int                       verdict_errors,
   output int                       verdicts_pending
);

   typedef struct {
      logic [INDEX_W-1:0] pixel;
      logic               foreground;
   } verdict_type;

   logic [CHANNELS-1:0][MEAN_W-1:0] mean_mem    [0:PIXEL_COUNT-1];
   logic [CHANNELS-1:0][WORD_W-1:0] diag_mem    [0:PIXEL_COUNT-1];
   logic [CHANNELS-1:0][WORD_W-1:0] offdiag_mem [0:PIXEL_COUNT-1];
   logic [THRESH_W-1:0]             thresh;
   verdict_type                     pending_verdicts [$];

   function automatic logic [MEAN_W-1:0] clamp_mean(input logic signed [WORD_W-1:0] w);
      if (w < 0) return '0;
      if (w > 20'sd65535) return '1;
      return w[MEAN_W-1:0];
   endfunction

   function automatic logic mahalanobis_foreground(input logic [INDEX_W-1:0] pix,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] g,
                                                   input logic [BYTE_W-1:0] r);
      longint d [3];
      longint cd [3];
      longint co [3];
      longint q;
      longint bound;
      d[0] = longint'({b, 8'h00}) - longint'(mean_mem[pix][0]);
      d[1] = longint'({g, 8'h00}) - longint'(mean_mem[pix][1]);
      d[2] = longint'({r, 8'h00}) - longint'(mean_mem[pix][2]);
      for (int k = 0; k < CHANNELS; k++) begin
         cd[k] = longint'($signed(diag_mem[pix][k]));
         co[k] = longint'($signed(offdiag_mem[pix][k]));
      end
      q = cd[0] * d[0] * d[0] + cd[1] * d[1] * d[1] + cd[2] * d[2] * d[2]
        + 2 * (co[0] * d[0] * d[1] + co[1] * d[0] * d[2] + co[2] * d[1] * d[2]);
      bound = longint'({thresh, 24'h000000});
      return (q < 0) || (q >= bound);
   endfunction

   task automatic note_fault();
      verdict_errors++;
   endtask

   always @(posedge clock) begin
      verdict_type head;
      if (reset) begin
         thresh = THRESH_RESET;
         pending_verdicts.delete();
         verdict_errors = 0;
      end else begin
         if (csr_wr_en) begin
            thresh = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               note_fault();
               if (verdict_errors <= 10) begin
                  $display("Result error: expected no transfer, got index %0d fg %0b",
                           rsp_out_index, rsp_foreground);
               end
            end else begin
               head = pending_verdicts.pop_front();
               if (rsp_out_index !== head.pixel || rsp_foreground !== head.foreground) begin
                  note_fault();
                  if (verdict_errors <= 10) begin
                     $display("Result error: expected index %0d fg %0b, got index %0d fg %0b",
                              head.pixel, head.foreground, rsp_out_index, rsp_foreground);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            case (opcode_type'(req_opcode))
               OP_LOAD_MEAN: begin
                  mean_mem[req_pixel_index] = {clamp_mean(req_word_third),
                                               clamp_mean(req_word_second),
                                               clamp_mean(req_word_first)};
               end
               OP_LOAD_DIAG: begin
                  diag_mem[req_pixel_index] = {req_word_third, req_word_second,
                                               req_word_first};
               end
               OP_LOAD_OFFDIAG: begin
                  offdiag_mem[req_pixel_index] = {req_word_third, req_word_second,
                                                  req_word_first};
               end
               default: begin
                  head.pixel = req_pixel_index;
                  head.foreground = mahalanobis_foreground(req_pixel_index, req_blue,
                                                           req_green, req_red);
                  pending_verdicts.insert(pending_verdicts.size(), head);
               end
            endcase
         end
      end
      verdicts_pending = pending_verdicts.size();
   end

endmodule

// ----- tb/sv/mahalanobis_background_classifier_top_tb.sv -----
// Testbench top for the Mahalanobis background classifier: clock, reset, model
// loads and classify traffic with random idling, threshold changes and the verdict.
// Depends on mbc_pkg, the classifier top level and mbc_foreground_checker.
module mahalanobis_background_classifier_top_tb;
   import mbc_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_opcode;
   logic [INDEX_W-1:0]       req_pixel_index;
   logic [BYTE_W-1:0]        req_blue;
   logic [BYTE_W-1:0]        req_green;
   logic [BYTE_W-1:0]        req_red;
   logic signed [WORD_W-1:0] req_word_first;
   logic signed [WORD_W-1:0] req_word_second;
   logic signed [WORD_W-1:0] req_word_third;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [INDEX_W-1:0]       rsp_out_index;
   logic                     rsp_foreground;
   logic                     csr_wr_en;
   logic [THRESH_W-1:0]      csr_wr_data;

   int verdict_errors;
   int verdicts_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;

   bit mean_loaded    [0:PIXEL_COUNT-1];
   bit diag_loaded    [0:PIXEL_COUNT-1];
   bit offdiag_loaded [0:PIXEL_COUNT-1];
   bit in_pool        [0:PIXEL_COUNT-1];
   logic [INDEX_W-1:0] ready_pixels [$];

   mahalanobis_background_classifier_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pixel_index (req_pixel_index),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .req_word_first  (req_word_first),
      .req_word_second (req_word_second),
      .req_word_third  (req_word_third),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_foreground  (rsp_foreground),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   mbc_foreground_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_pixel_index  (req_pixel_index),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_word_first   (req_word_first),
      .req_word_second  (req_word_second),
      .req_word_third   (req_word_third),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_index    (rsp_out_index),
      .rsp_foreground   (rsp_foreground),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .verdict_errors   (verdict_errors),
      .verdicts_pending (verdicts_pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic signed [WORD_W-1:0] rand_word();
      return WORD_W'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [BYTE_W-1:0] near_byte(input int center);
      int v;
      v = center + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return BYTE_W'(v);
   endfunction

   task automatic send_item(input opcode_type op, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] g,
                            input logic [BYTE_W-1:0] r,
                            input logic signed [WORD_W-1:0] w0,
                            input logic signed [WORD_W-1:0] w1,
                            input logic signed [WORD_W-1:0] w2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pixel_index <= idx;
      req_blue        <= b;
      req_green       <= g;
      req_red         <= r;
      req_word_first  <= w0;
      req_word_second <= w1;
      req_word_third  <= w2;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      case (op)
         OP_LOAD_MEAN:    mean_loaded[idx] = 1'b1;
         OP_LOAD_DIAG:    diag_loaded[idx] = 1'b1;
         OP_LOAD_OFFDIAG: offdiag_loaded[idx] = 1'b1;
         default: ;
      endcase
      if (mean_loaded[idx] && diag_loaded[idx] && offdiag_loaded[idx] && !in_pool[idx]) begin
         in_pool[idx] = 1'b1;
         ready_pixels.insert(ready_pixels.size(), idx);
      end
   endtask

   task automatic load_part(input opcode_type op, input logic [INDEX_W-1:0] idx,
                            input logic signed [WORD_W-1:0] w0,
                            input logic signed [WORD_W-1:0] w1,
                            input logic signed [WORD_W-1:0] w2);
      send_item(op, idx, rand_byte(), rand_byte(), rand_byte(), w0, w1, w2);
   endtask

   task automatic classify(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] b,
                           input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] r);
      send_item(OP_CLASSIFY, idx, b, g, r, rand_word(), rand_word(), rand_word());
   endtask

   task automatic set_threshold(input logic [THRESH_W-1:0] value);
      req_valid <= 1'b0;
      wait (verdicts_pending == 0);
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int stop_at;
      int roll;
      int swap_at;
      int tmp;
      int mb [3];
      int order [3];
      bit lifelike;
      logic [INDEX_W-1:0] idx;
      logic signed [WORD_W-1:0] mw [3];
      logic signed [WORD_W-1:0] dw [3];
      logic signed [WORD_W-1:0] ow [3];
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 60 || ready_pixels.size() == 0) begin
            if ($urandom_range(4) == 0 && ready_pixels.size() > 0) begin
               idx = ready_pixels[$urandom_range(ready_pixels.size() - 1)];
            end else begin
               idx = INDEX_W'($urandom);
            end
            lifelike = 1'($urandom_range(1));
            for (int k = 0; k < 3; k++) begin
               mb[k] = $urandom_range(255);
               if (lifelike) begin
                  mw[k] = WORD_W'(mb[k] * 256 + int'($urandom_range(255)));
                  dw[k] = WORD_W'($urandom_range(1, 8192));
                  ow[k] = WORD_W'(int'($urandom_range(2047)) - 1024);
               end else begin
                  mw[k] = rand_word();
                  dw[k] = rand_word();
                  ow[k] = rand_word();
               end
               order[k] = k;
            end
            for (int k = 2; k > 0; k--) begin
               swap_at = $urandom_range(k);
               tmp = order[k];
               order[k] = order[swap_at];
               order[swap_at] = tmp;
            end
            for (int k = 0; k < 3; k++) begin
               case (order[k])
                  0: load_part(OP_LOAD_MEAN, idx, mw[0], mw[1], mw[2]);
                  1: load_part(OP_LOAD_DIAG, idx, dw[0], dw[1], dw[2]);
                  default: load_part(OP_LOAD_OFFDIAG, idx, ow[0], ow[1], ow[2]);
               endcase
            end
            repeat ($urandom_range(1, 4)) begin
               if (lifelike && $urandom_range(3) != 0) begin
                  classify(idx, near_byte(mb[0]), near_byte(mb[1]), near_byte(mb[2]));
               end else begin
                  classify(idx, rand_byte(), rand_byte(), rand_byte());
               end
            end
         end else if (roll < 80) begin
            classify(ready_pixels[$urandom_range(ready_pixels.size() - 1)],
                     rand_byte(), rand_byte(), rand_byte());
         end else if (roll < 90) begin
            idx = INDEX_W'($urandom);
            repeat ($urandom_range(1, 2)) begin
               load_part(opcode_type'($urandom_range(2)), idx, rand_word(), rand_word(),
                         rand_word());
            end
         end else begin
            load_part(opcode_type'($urandom_range(2)),
                      ready_pixels[$urandom_range(ready_pixels.size() - 1)],
                      rand_word(), rand_word(), rand_word());
         end
      end
   endtask

   initial begin
      logic [THRESH_W-1:0] phase_thresh [6];
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_LOAD_MEAN;
      req_pixel_index = '0;
      req_blue        = '0;
      req_green       = '0;
      req_red         = '0;
      req_word_first  = '0;
      req_word_second = '0;
      req_word_third  = '0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      send_idle_pct   = 33;
      recv_idle_pct   = 71;
      items_sent      = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unit covariance at pixel 0 puts a red step of three levels exactly on the
      // default threshold of 9.0.
      load_part(OP_LOAD_MEAN, 16'h0000, 20'h00000, 20'h00000, 20'h00000);
      load_part(OP_LOAD_DIAG, 16'h0000, 20'h10000, 20'h10000, 20'h10000);
      load_part(OP_LOAD_OFFDIAG, 16'h0000, 20'h00000, 20'h00000, 20'h00000);
      classify(16'h0000, 8'd0, 8'd0, 8'd0);
      classify(16'h0000, 8'd0, 8'd0, 8'd3);
      classify(16'h0000, 8'd0, 8'd0, 8'd2);
      classify(16'h0000, 8'd255, 8'd255, 8'd255);
      load_part(OP_LOAD_MEAN, 16'hFFFF, 20'h80000, 20'h7FFFF, 20'h0FFFF);
      load_part(OP_LOAD_DIAG, 16'hFFFF, 20'h7FFFF, 20'h80000, 20'hFFFFF);
      load_part(OP_LOAD_OFFDIAG, 16'hFFFF, 20'h80000, 20'h7FFFF, 20'h00000);
      classify(16'hFFFF, 8'd255, 8'd0, 8'd255);
      classify(16'hFFFF, 8'd0, 8'd255, 8'd128);
      load_part(OP_LOAD_MEAN, 16'h0001, 20'h08000, 20'h08000, 20'h08000);
      load_part(OP_LOAD_DIAG, 16'h0001, 20'hF0000, 20'hF0000, 20'hF0000);
      load_part(OP_LOAD_OFFDIAG, 16'h0001, 20'h00000, 20'h00000, 20'h00000);
      classify(16'h0001, 8'd130, 8'd128, 8'd128);
      classify(16'h0001, 8'd128, 8'd128, 8'd128);

      phase_thresh[0] = 32'hFFFF_FFFF;
      phase_thresh[1] = 32'd0;
      phase_thresh[2] = $urandom_range(500, 20000);
      phase_thresh[3] = THRESH_RESET;
      phase_thresh[4] = $urandom;
      phase_thresh[5] = $urandom_range(1, 5000);
      for (int p = 0; p < 6; p++) begin
         set_threshold(phase_thresh[p]);
         case (p / 2)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         random_traffic(134);
      end

      req_valid <= 1'b0;
      wait (verdicts_pending == 0);
      repeat (10) @(posedge clock);
      if (verdict_errors == 0 && verdicts_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mbc_pkg.sv
rtl/core/mahalanobis_background_classifier_top.sv
tb/sv/mbc_foreground_checker.sv
tb/sv/mahalanobis_background_classifier_top_tb.sv
